@@ design/sample_moment_statistics_assert.svh @@
// Assertion macros, clocked on i_clk with the synchronous reset i_rst_n held off.
`ifndef SAMPLE_MOMENT_STATISTICS_ASSERT_SVH
`define SAMPLE_MOMENT_STATISTICS_ASSERT_SVH

`ifndef ASSERT_OFF
`define SMS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sms assertion failed");
`define SMS_NEVER(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(prop)) \
        else $error("sms forbidden condition seen");
`else
`define SMS_ASSERT(label, prop)
`define SMS_NEVER(label, prop)
`endif

`endif

@@ design/sms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MEAN_W     = 40;
    localparam int STD_W      = 40;
    localparam int SKEW_W     = 32;
    localparam int KURT_W     = 36;
    localparam int TOTAL_W    = 13;
    localparam int SHAPE_FRAC = 24;

    localparam logic [SKEW_W-1:0] SKEW_MAX = {1'b0, {(SKEW_W-1){1'b1}}};
    localparam logic [SKEW_W-1:0] SKEW_MIN = {1'b1, {(SKEW_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FLAT = 2'd2,
        ST_DROP = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in;

    typedef struct packed {
        logic [MEAN_W-1:0]        mean_fx;
        logic [STD_W-1:0]         std_fx;
        logic signed [SKEW_W-1:0] skew_fx;
        logic [KURT_W-1:0]        kurt_fx;
        logic [TOTAL_W-1:0]       sample_total;
        t_status                  status;
    } t_out;

endpackage

`default_nettype wire

@@ design/sms_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sample store: one write port, one registered read port.
module sms_store #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/sms_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial wide unit: shift-add multiply, restoring divide, restoring square root.
module sms_alu #(
    parameter int BW    = 310,
    parameter int LEN_W = 9
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sms_pkg::t_alu_req   i_req,
    input  wire logic [LEN_W-1:0]    i_len,
    input  wire logic [BW-1:0]       i_a,
    input  wire logic [BW-1:0]       i_b,
    output sms_pkg::t_alu_stat       o_stat,
    output logic      [BW-1:0]       o_res
);
    import sms_pkg::*;

    localparam int HW = BW / 2;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    t_alu_op         r_op;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [BW-1:0]   r_x, n_x;
    logic [BW-1:0]   r_y, n_y;
    logic [BW-1:0]   r_acc, n_acc;
    logic [HW-1:0]   r_root, n_root;

    logic [BW:0]     div_sh;
    logic            div_ge;
    logic [HW+2:0]   sq_sh;
    logic [HW+2:0]   sq_trial;
    logic            sq_ge;

    always_comb begin
        div_sh   = {r_acc, r_x[BW-1]};
        div_ge   = div_sh >= {1'b0, r_y};
        sq_sh    = {r_acc[HW:0], r_x[BW-1:BW-2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_root = r_root;
        if (i_req.go && !r_busy) begin
            n_busy = 1'b1;
            n_x    = i_a;
            n_y    = i_b;
            n_acc  = '0;
            n_root = '0;
            case (i_req.op)
                OP_MUL:  n_cnt = i_len;
                OP_DIV:  n_cnt = LEN_W'(BW);
                OP_SQRT: n_cnt = LEN_W'(HW);
                default: n_cnt = i_len;
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == LEN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) begin
                        n_acc = r_acc + r_x;
                    end
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
                OP_DIV: begin
                    n_acc = div_ge ? BW'(div_sh - {1'b0, r_y}) : div_sh[BW-1:0];
                    n_x   = {r_x[BW-2:0], div_ge};
                end
                OP_SQRT: begin
                    n_acc  = BW'(sq_ge ? sq_sh - sq_trial : sq_sh);
                    n_x    = r_x << 2;
                    n_root = {r_root[HW-2:0], sq_ge};
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_op <= i_req.op;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_root <= n_root;
    end

    always_comb begin
        case (r_op)
            OP_MUL:  o_res = r_acc;
            OP_DIV:  o_res = r_x;
            OP_SQRT: o_res = BW'(r_root);
            default: o_res = r_acc;
        endcase
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ design/sample_moment_statistics.sv @@
// Load: one sample transfer per cycle while busy is low; results need no stall (strobe o_done).
// After the transfer flagged last, the time to the result is set by the bit-serial wide unit,
// shared by the store walk and the final stages. DW = SAMPLE_BITS+clog2(MAX_SAMPLES+1),
// BW ~ 6*DW+3*clog2(..)+48 is the wide unit's operand width.
// o_done is high one cycle; busy drops in that cycle so the next set may start at once.
// Synchronous active-low reset clears the count, drop flag and sequencer; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "sample_moment_statistics_assert.svh"

module sample_moment_statistics #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    input  wire sms_pkg::t_in i_in,
    output logic        busy,
    output logic        o_done,
    output sms_pkg::t_out o_out
);
    import sms_pkg::*;

    // widths of the running quantities
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int D_W    = SAMPLE_BITS + CNT_W;      // |n*x - sum|
    localparam int A2_W   = 2 * D_W + CNT_W;
    localparam int A3_W   = 3 * D_W + CNT_W;
    localparam int A4_W   = 4 * D_W + CNT_W;
    localparam int BW_RAW = 2 * A3_W + CNT_W + 2 * SHAPE_FRAC;
    localparam int BW     = BW_RAW + (BW_RAW % 2);    // widest operand, even for the root
    localparam int LEN_W  = $clog2(BW + 1);

    // sequencer: one-hot
    typedef enum logic [21:0] {
        S_IDLE = 22'd1 << 0,
        S_MEAN = 22'd1 << 1,   // sum * 2^F / n
        S_RD   = 22'd1 << 2,   // issue store read
        S_NX   = 22'd1 << 3,   // n * x
        S_DEV  = 22'd1 << 4,   // |n*x - sum|
        S_SQ   = 22'd1 << 5,   // d^2
        S_CU   = 22'd1 << 6,   // d^3
        S_QU   = 22'd1 << 7,   // d^4
        S_FIN  = 22'd1 << 8,   // signed third moment, early exit
        S_D1   = 22'd1 << 9,   // n^2
        S_D2   = 22'd1 << 10,  // n^2 (n-1)
        S_D3   = 22'd1 << 11,  // variance quotient
        S_D4   = 22'd1 << 12,  // root -> std
        S_S1   = 22'd1 << 13,  // A2^2
        S_S2   = 22'd1 << 14,  // A2^3
        S_S3   = 22'd1 << 15,  // A3^2
        S_S4   = 22'd1 << 16,  // A3^2 n
        S_S5   = 22'd1 << 17,  // skew^2 quotient
        S_S6   = 22'd1 << 18,  // root -> skew
        S_K1   = 22'd1 << 19,  // A4 n
        S_K2   = 22'd1 << 20,  // kurtosis quotient
        S_OUT  = 22'd1 << 21
    } t_state;

    t_state r_state, n_state;

    logic                   r_done;
    t_out                   r_out;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_ovf;
    logic [D_W-1:0]         r_sum;
    logic [CNT_W-1:0]       r_idx;
    logic [D_W-1:0]         r_nx;
    logic [D_W-1:0]         r_d;
    logic                   r_neg;
    logic [2*D_W-1:0]       r_d2;
    logic [A2_W-1:0]        r_a2;
    logic [A3_W-1:0]        r_p3, r_n3, r_a3;
    logic                   r_neg3;
    logic [A4_W-1:0]        r_a4;
    logic [BW-1:0]          r_t, r_u, r_v;
    logic                   r_sent;
    logic [MEAN_W-1:0]      r_mean;
    logic [STD_W-1:0]       r_std;
    logic [SKEW_W-1:0]      r_skew;
    logic [KURT_W-1:0]      r_kurt;

    logic                   in_xfer;
    logic [31:0]            in_ext;
    logic [SAMPLE_BITS-1:0] in_x;
    logic                   store_we;
    logic [SAMPLE_BITS-1:0] rdata;

    logic                   in_alu;
    t_alu_req               alu_req;
    t_alu_stat              alu_stat;
    logic [LEN_W-1:0]       alu_len;
    logic [BW-1:0]          alu_a, alu_b, alu_res;
    logic                   alu_fin;

    logic [MEAN_W-1:0]      res_sat40;
    logic [SKEW_W-1:0]      res_skew;
    logic [KURT_W-1:0]      res_kurt;
    t_status                status;

    // ---------------------------------------------------------------- load
    assign busy     = (r_state != S_IDLE);
    assign in_xfer  = start && !busy;
    assign in_ext   = 32'(i_in.sample);
    assign in_x     = in_ext[SAMPLE_BITS-1:0];
    assign store_we = in_xfer && (r_cnt < CNT_W'(MAX_SAMPLES));

    sms_store #(
        .DEPTH  (MAX_SAMPLES),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (in_x),
        .i_re    (r_state == S_RD),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // ---------------------------------------------------------------- wide unit
    // Every wide step is one operation of the shared unit; the state picks operands.
    always_comb begin
        in_alu     = 1'b1;
        alu_req.op = OP_MUL;
        alu_a      = '0;
        alu_b      = '0;
        alu_len    = '0;
        case (r_state)
            S_MEAN: begin
                alu_req.op = OP_DIV;
                alu_a      = BW'(r_sum) << FRAC_BITS;
                alu_b      = BW'(r_cnt);
            end
            S_SQ: begin
                alu_a   = BW'(r_d);
                alu_b   = BW'(r_d);
                alu_len = LEN_W'(D_W);
            end
            S_CU: begin
                alu_a   = BW'(r_d2);
                alu_b   = BW'(r_d);
                alu_len = LEN_W'(D_W);
            end
            S_QU: begin
                alu_a   = BW'(r_d2);
                alu_b   = BW'(r_d2);
                alu_len = LEN_W'(2 * D_W);
            end
            S_D1: begin
                alu_a   = BW'(r_cnt);
                alu_b   = BW'(r_cnt);
                alu_len = LEN_W'(CNT_W);
            end
            S_D2: begin
                alu_a   = r_t;
                alu_b   = BW'(r_cnt - 1'b1);
                alu_len = LEN_W'(CNT_W);
            end
            S_D3: begin
                alu_req.op = OP_DIV;
                alu_a      = BW'(r_a2) << (2 * FRAC_BITS);
                alu_b      = r_t;
            end
            S_D4, S_S6: begin
                alu_req.op = OP_SQRT;
                alu_a      = r_t;
            end
            S_S1: begin
                alu_a   = BW'(r_a2);
                alu_b   = BW'(r_a2);
                alu_len = LEN_W'(A2_W);
            end
            S_S2: begin
                alu_a   = r_u;
                alu_b   = BW'(r_a2);
                alu_len = LEN_W'(A2_W);
            end
            S_S3: begin
                alu_a   = BW'(r_a3);
                alu_b   = BW'(r_a3);
                alu_len = LEN_W'(A3_W);
            end
            S_S4: begin
                alu_a   = r_t;
                alu_b   = BW'(r_cnt);
                alu_len = LEN_W'(CNT_W);
            end
            S_S5: begin
                alu_req.op = OP_DIV;
                alu_a      = r_t << (2 * SHAPE_FRAC);
                alu_b      = r_v;
            end
            S_K1: begin
                alu_a   = BW'(r_a4);
                alu_b   = BW'(r_cnt);
                alu_len = LEN_W'(CNT_W);
            end
            S_K2: begin
                alu_req.op = OP_DIV;
                alu_a      = r_t << SHAPE_FRAC;
                alu_b      = r_u;
            end
            default: begin
                in_alu = 1'b0;
            end
        endcase
        alu_req.go = in_alu && !r_sent;
    end

    sms_alu #(
        .BW    (BW),
        .LEN_W (LEN_W)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_len   (alu_len),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_stat  (alu_stat),
        .o_res   (alu_res)
    );

    assign alu_fin = in_alu && r_sent && alu_stat.done;

    // saturation and sign of the finished quotients
    always_comb begin
        res_sat40 = (|alu_res[BW-1:MEAN_W]) ? '1 : alu_res[MEAN_W-1:0];
        res_kurt  = (|alu_res[BW-1:KURT_W]) ? '1 : alu_res[KURT_W-1:0];
        if (r_neg3) begin
            res_skew = (|alu_res[BW-1:SKEW_W-1]) ? SKEW_MIN : SKEW_W'(-alu_res[SKEW_W-1:0]);
        end else begin
            res_skew = (|alu_res[BW-1:SKEW_W-1]) ? SKEW_MAX : alu_res[SKEW_W-1:0];
        end
        if (r_cnt < CNT_W'(2)) begin
            status = ST_FEW;
        end else if (r_ovf) begin
            status = ST_DROP;
        end else if (r_a2 == '0) begin
            status = ST_FLAT;
        end else begin
            status = ST_OK;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer && i_in.last) n_state = S_MEAN;
            S_MEAN: if (alu_fin) n_state = S_RD;
            S_RD:   n_state = S_NX;
            S_NX:   n_state = S_DEV;
            S_DEV:  n_state = S_SQ;
            S_SQ:   if (alu_fin) n_state = S_CU;
            S_CU:   if (alu_fin) n_state = S_QU;
            S_QU: begin
                if (alu_fin) begin
                    n_state = (r_idx + 1'b1 == r_cnt) ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                n_state = (r_cnt < CNT_W'(2) || r_a2 == '0) ? S_OUT : S_D1;
            end
            S_D1:   if (alu_fin) n_state = S_D2;
            S_D2:   if (alu_fin) n_state = S_D3;
            S_D3:   if (alu_fin) n_state = S_D4;
            S_D4:   if (alu_fin) n_state = S_S1;
            S_S1:   if (alu_fin) n_state = S_S2;
            S_S2:   if (alu_fin) n_state = S_S3;
            S_S3:   if (alu_fin) n_state = S_S4;
            S_S4:   if (alu_fin) n_state = S_S5;
            S_S5:   if (alu_fin) n_state = S_S6;
            S_S6:   if (alu_fin) n_state = S_K1;
            S_K1:   if (alu_fin) n_state = S_K2;
            S_K2:   if (alu_fin) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sent  <= 1'b0;
            r_done  <= 1'b0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_OUT);
            if (alu_req.go) begin
                r_sent <= 1'b1;
            end else if (alu_fin) begin
                r_sent <= 1'b0;
            end
            if (store_we) begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + D_W'(in_x);
            end else if (in_xfer) begin
                r_ovf <= 1'b1;    // store full: sample dropped
            end
            if (r_state == S_MEAN) begin
                r_idx <= '0;
            end else if (r_state == S_QU && alu_fin) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_OUT) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
                r_sum <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a2   <= '0;
                r_p3   <= '0;
                r_n3   <= '0;
                r_a4   <= '0;
                r_std  <= '0;
                r_skew <= '0;
                r_kurt <= '0;
            end
            S_MEAN: if (alu_fin) r_mean <= res_sat40;
            S_NX:   r_nx <= D_W'(r_cnt) * D_W'(rdata);
            S_DEV: begin
                r_neg <= r_nx < r_sum;
                r_d   <= (r_nx < r_sum) ? r_sum - r_nx : r_nx - r_sum;
            end
            S_SQ: begin
                if (alu_fin) begin
                    r_d2 <= alu_res[2*D_W-1:0];
                    r_a2 <= r_a2 + alu_res[A2_W-1:0];
                end
            end
            S_CU: begin
                if (alu_fin) begin
                    if (r_neg) begin
                        r_n3 <= r_n3 + alu_res[A3_W-1:0];
                    end else begin
                        r_p3 <= r_p3 + alu_res[A3_W-1:0];
                    end
                end
            end
            S_QU:   if (alu_fin) r_a4 <= r_a4 + alu_res[A4_W-1:0];
            S_FIN: begin
                r_neg3 <= r_p3 < r_n3;
                r_a3   <= (r_p3 < r_n3) ? r_n3 - r_p3 : r_p3 - r_n3;
            end
            S_D1, S_D2, S_D3, S_S3, S_S4, S_S5, S_K1: begin
                if (alu_fin) r_t <= alu_res;
            end
            S_D4:   if (alu_fin) r_std <= res_sat40;
            S_S1:   if (alu_fin) r_u <= alu_res;
            S_S2:   if (alu_fin) r_v <= alu_res;
            S_S6:   if (alu_fin) r_skew <= res_skew;
            S_K2:   if (alu_fin) r_kurt <= res_kurt;
            S_OUT: begin
                r_out.mean_fx      <= r_mean;
                r_out.std_fx       <= r_std;
                r_out.skew_fx      <= r_skew;
                r_out.kurt_fx      <= r_kurt;
                r_out.sample_total <= TOTAL_W'(r_cnt);
                r_out.status       <= status;
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // ---------------------------------------------------------------- checks
    `SMS_ASSERT(a_last_goes_busy, (in_xfer && i_in.last) |=> busy)
    `SMS_ASSERT(a_done_single, o_done |=> !o_done)
    `SMS_NEVER(a_cnt_range, r_cnt > CNT_W'(MAX_SAMPLES))
    `SMS_ASSERT(a_alu_done_owned, alu_stat.done |-> r_sent)

endmodule

`default_nettype wire
